>>> src/ctn_pkg.sv
// Shared types and constants for the config text normalizer.
`timescale 1ns / 1ps

package ctn_pkg;

  localparam int LENGTH_BITS_DEF = 20;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_BITS-1:0] CFG_COMMENT_A = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COMMENT_B = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COMMENT_C = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COMMENT_D = 2'd3;

  localparam logic [7:0] COMMENT_A_RST = 8'd59;
  localparam logic [7:0] COMMENT_B_RST = 8'd35;
  localparam logic [7:0] COMMENT_C_RST = 8'd0;
  localparam logic [7:0] COMMENT_D_RST = 8'd0;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_NL  = 8'h0A;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_BSL = 8'h5C;

  typedef enum logic [1:0] {
    MODE_START   = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_LINE    = 2'd2
  } ctn_mode_t;

  // One result entry, without its length.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       term;
  } ctn_ent_t;

  // Results that one input byte produces.
  typedef struct packed {
    logic [1:0] num;
    ctn_ent_t   e0;
    ctn_ent_t   e1;
  } ctn_push_t;

endpackage

>>> src/ctn_step.sv
// Per-byte decode: results and next scan state for one input byte.
`timescale 1ns / 1ps

module ctn_step #(
  parameter int LENGTH_BITS = ctn_pkg::LENGTH_BITS_DEF
) (
  input  logic [7:0]             byte_i,
  input  ctn_pkg::ctn_mode_t     mode_i,
  input  logic                   held_i,
  input  logic [LENGTH_BITS-1:0] count_i,
  input  logic [7:0]             cmt_a_i,
  input  logic [7:0]             cmt_b_i,
  input  logic [7:0]             cmt_c_i,
  input  logic [7:0]             cmt_d_i,
  output ctn_pkg::ctn_push_t     push_o,
  output logic [LENGTH_BITS-1:0] len_o,
  output ctn_pkg::ctn_mode_t     mode_o,
  output logic                   held_o,
  output logic [LENGTH_BITS-1:0] count_o
);

  localparam logic [LENGTH_BITS-1:0] CountMax = {LENGTH_BITS{1'b1}};

  logic [LENGTH_BITS-1:0] inc1;
  logic [LENGTH_BITS-1:0] inc2;
  logic                   is_cmt;
  ctn_pkg::ctn_ent_t      ent_b;
  ctn_pkg::ctn_ent_t      ent_sp;
  ctn_pkg::ctn_ent_t      ent_bsl;
  ctn_pkg::ctn_ent_t      ent_end;

  assign inc1 = (count_i == CountMax) ? count_i : count_i + 1'b1;
  assign inc2 = (inc1 == CountMax) ? inc1 : inc1 + 1'b1;

  assign is_cmt = (cmt_a_i != ctn_pkg::CH_NUL && byte_i == cmt_a_i) ||
                  (cmt_b_i != ctn_pkg::CH_NUL && byte_i == cmt_b_i) ||
                  (cmt_c_i != ctn_pkg::CH_NUL && byte_i == cmt_c_i) ||
                  (cmt_d_i != ctn_pkg::CH_NUL && byte_i == cmt_d_i);

  assign ent_b   = '{data: byte_i,          last: 1'b0, term: 1'b0};
  assign ent_sp  = '{data: ctn_pkg::CH_SP,  last: 1'b0, term: 1'b0};
  assign ent_bsl = '{data: ctn_pkg::CH_BSL, last: 1'b0, term: 1'b0};
  assign ent_end = '{data: ctn_pkg::CH_NUL, last: 1'b1, term: 1'b1};

  always_comb begin
    push_o  = '0;
    len_o   = '0;
    mode_o  = mode_i;
    held_o  = held_i;
    count_o = count_i;
    case (mode_i)
      ctn_pkg::MODE_LINE: begin
        if (held_i) begin
          held_o = 1'b0;
          if (byte_i == ctn_pkg::CH_NL) begin
            // Line continuation: the backslash turns into a space.
            push_o.num     = 2'd1;
            push_o.e0      = ent_sp;
            push_o.e0.last = 1'b1;
            mode_o         = ctn_pkg::MODE_START;
            count_o        = inc1;
          end else if (byte_i == ctn_pkg::CH_NUL) begin
            push_o.num = 2'd2;
            push_o.e0  = ent_sp;
            push_o.e1  = ent_end;
            len_o      = inc1;
            mode_o     = ctn_pkg::MODE_START;
            count_o    = '0;
          end else if (byte_i == ctn_pkg::CH_BSL) begin
            push_o.num     = 2'd1;
            push_o.e0      = ent_bsl;
            push_o.e0.last = 1'b1;
            held_o         = 1'b1;
            count_o        = inc1;
          end else begin
            push_o.num     = 2'd2;
            push_o.e0      = ent_bsl;
            push_o.e1      = ent_b;
            push_o.e1.last = 1'b1;
            count_o        = inc2;
          end
        end else if (byte_i == ctn_pkg::CH_NUL) begin
          push_o.num = 2'd1;
          push_o.e0  = ent_end;
          len_o      = count_i;
          mode_o     = ctn_pkg::MODE_START;
          count_o    = '0;
        end else if (byte_i == ctn_pkg::CH_BSL) begin
          held_o = 1'b1;
        end else begin
          push_o.num     = 2'd1;
          push_o.e0      = ent_b;
          push_o.e0.last = 1'b1;
          count_o        = inc1;
          if (byte_i == ctn_pkg::CH_NL) begin
            mode_o = ctn_pkg::MODE_START;
          end
        end
      end
      ctn_pkg::MODE_COMMENT: begin
        if (byte_i == ctn_pkg::CH_NUL) begin
          push_o.num = 2'd1;
          push_o.e0  = ent_end;
          len_o      = count_i;
          mode_o     = ctn_pkg::MODE_START;
          held_o     = 1'b0;
          count_o    = '0;
        end else if (byte_i == ctn_pkg::CH_NL) begin
          mode_o = ctn_pkg::MODE_START;
        end
      end
      default: begin
        // Line start; the unused mode code behaves the same way.
        mode_o = ctn_pkg::MODE_START;
        if (byte_i == ctn_pkg::CH_NUL) begin
          push_o.num = 2'd1;
          push_o.e0  = ent_end;
          len_o      = count_i;
          held_o     = 1'b0;
          count_o    = '0;
        end else if (byte_i == ctn_pkg::CH_NL || byte_i == ctn_pkg::CH_SP ||
                     byte_i == ctn_pkg::CH_TAB) begin
          mode_o = ctn_pkg::MODE_START;
        end else if (is_cmt) begin
          mode_o = ctn_pkg::MODE_COMMENT;
        end else if (byte_i == ctn_pkg::CH_BSL) begin
          mode_o = ctn_pkg::MODE_LINE;
          held_o = 1'b1;
        end else begin
          mode_o         = ctn_pkg::MODE_LINE;
          push_o.num     = 2'd1;
          push_o.e0      = ent_b;
          push_o.e0.last = 1'b1;
          count_o        = inc1;
        end
      end
    endcase
  end

endmodule

>>> src/ctn_outq.sv
// Two-entry result buffer that drives the output channel.
`timescale 1ns / 1ps

module ctn_outq #(
  parameter int LENGTH_BITS = ctn_pkg::LENGTH_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push_i,
  input  ctn_pkg::ctn_push_t     push_data_i,
  input  logic [LENGTH_BITS-1:0] push_len_i,
  output logic                   room_o,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   out_run_last,
  output logic                   out_text_end,
  output logic [LENGTH_BITS-1:0] out_text_length
);

  logic [1:0]             cnt_r, cnt_nxt;
  ctn_pkg::ctn_ent_t      slot0_r, slot0_nxt;
  ctn_pkg::ctn_ent_t      slot1_r, slot1_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic                   pop;

  assign pop       = out_valid && out_ready;
  // New results may enter once the head slot empties in this cycle.
  assign room_o    = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_ready);
  assign out_valid = (cnt_r != 2'd0);

  assign out_byte        = slot0_r.data;
  assign out_run_last    = slot0_r.last;
  assign out_text_end    = slot0_r.term;
  assign out_text_length = slot0_r.term ? len_r : '0;

  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    len_nxt   = len_r;
    if (push_i) begin
      cnt_nxt   = push_data_i.num;
      slot0_nxt = push_data_i.e0;
      slot1_nxt = push_data_i.e1;
      len_nxt   = push_len_i;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
    len_r   <= len_nxt;
  end

endmodule

>>> src/config_text_normalizer_top.sv
// Top level of the config text normalizer.
`timescale 1ns / 1ps

// Strips leading blanks and comment lines from a zero-terminated text stream,
// joins backslash-continued lines and ends each text with a zero byte that
// carries the saturating count of bytes emitted before it. One input byte is
// taken per cycle while it makes at most one result and out_ready is high; a
// byte with two results (held backslash, then another byte or the terminator)
// stalls input as they leave one at a time via the two-entry output buffer.
// Results appear in the cycle after the input transfer. The user must write
// comment characters via the cfg port while the block is idle (unchecked).
module config_text_normalizer_top #(
  parameter int LENGTH_BITS = ctn_pkg::LENGTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_byte,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [7:0]                       out_byte,
  output logic                             out_run_last,
  output logic                             out_text_end,
  output logic [LENGTH_BITS-1:0]           out_text_length,
  input  logic                             cfg_wr_en,
  input  logic [ctn_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ctn_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  logic [7:0]             cmt_a_r, cmt_b_r, cmt_c_r, cmt_d_r;
  ctn_pkg::ctn_mode_t     mode_r, mode_nxt;
  logic                   held_r, held_nxt;
  logic [LENGTH_BITS-1:0] count_r, count_nxt;
  ctn_pkg::ctn_push_t     push_data;
  logic [LENGTH_BITS-1:0] push_len;
  logic                   room;
  logic                   accept;

  assign in_ready = room;
  assign accept   = in_valid && room;

  ctn_step #(.LENGTH_BITS(LENGTH_BITS)) u_step (
    .byte_i  (in_byte),
    .mode_i  (mode_r),
    .held_i  (held_r),
    .count_i (count_r),
    .cmt_a_i (cmt_a_r),
    .cmt_b_i (cmt_b_r),
    .cmt_c_i (cmt_c_r),
    .cmt_d_i (cmt_d_r),
    .push_o  (push_data),
    .len_o   (push_len),
    .mode_o  (mode_nxt),
    .held_o  (held_nxt),
    .count_o (count_nxt)
  );

  ctn_outq #(.LENGTH_BITS(LENGTH_BITS)) u_outq (
    .clk             (clk),
    .rst_n           (rst_n),
    .push_i          (accept),
    .push_data_i     (push_data),
    .push_len_i      (push_len),
    .room_o          (room),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_text_end    (out_text_end),
    .out_text_length (out_text_length)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= ctn_pkg::MODE_START;
      held_r  <= 1'b0;
      count_r <= '0;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      held_r  <= held_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmt_a_r <= ctn_pkg::COMMENT_A_RST;
      cmt_b_r <= ctn_pkg::COMMENT_B_RST;
      cmt_c_r <= ctn_pkg::COMMENT_C_RST;
      cmt_d_r <= ctn_pkg::COMMENT_D_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ctn_pkg::CFG_COMMENT_A: cmt_a_r <= cfg_wdata;
        ctn_pkg::CFG_COMMENT_B: cmt_b_r <= cfg_wdata;
        ctn_pkg::CFG_COMMENT_C: cmt_c_r <= cfg_wdata;
        ctn_pkg::CFG_COMMENT_D: cmt_d_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> src/ctn_checker.sv
// Port-level checks for the config text normalizer, bound to the top level.
`timescale 1ns / 1ps

module ctn_checker #(
  parameter int LENGTH_BITS = ctn_pkg::LENGTH_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [7:0]             out_byte,
  input logic                   out_run_last,
  input logic                   out_text_end,
  input logic [LENGTH_BITS-1:0] out_text_length
);

  // The terminator is always the final result of its input byte.
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_end |-> out_run_last)
    else $error("terminator transfer without run_last");

  a_end_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_text_end |-> out_byte == ctn_pkg::CH_NUL)
    else $error("terminator transfer carries a nonzero byte");

  // Ordinary results never carry a zero byte or a length.
  a_data_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_text_end |-> out_byte != ctn_pkg::CH_NUL &&
    out_text_length == '0)
    else $error("data transfer with zero byte or nonzero length");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(out_text_end))
    else $error("stalled result changed");

endmodule

bind config_text_normalizer_top ctn_checker #(.LENGTH_BITS(LENGTH_BITS)) u_ctn_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_byte        (out_byte),
  .out_run_last    (out_run_last),
  .out_text_end    (out_text_end),
  .out_text_length (out_text_length)
);
